// ===== hw/rtl/dpd_pkg.sv =====
// Shared types and codes for the delimited packet deframer.
package dpd_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_DELIMITER = 2'd0;
  localparam logic [1:0] REG_HEAD      = 2'd1;
  localparam logic [1:0] REG_TAIL      = 2'd2;

  localparam logic [7:0] DELIMITER_RST = 8'd255;
  localparam logic [7:0] HEAD_RST      = 8'd0;
  localparam logic [7:0] TAIL_RST      = 8'd239;

  typedef struct packed {
    logic [7:0] delimiter_byte;
    logic [7:0] head_byte;
    logic [7:0] tail_byte;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [10:0] frame_length;
    logic        last;
  } res_t;

endpackage

// ===== hw/rtl/dpd_parser.sv =====
// Framing state machine: turns one byte into zero, one or two results.
module dpd_parser #(
  parameter int MAX_FRAME_LEN = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dpd_pkg::cfg_t     cfg,
  input  logic              fire,
  input  logic [7:0]        rx_byte,
  input  logic              burst_end,
  output logic [1:0]        res_cnt,
  output dpd_pkg::res_t     res0,
  output dpd_pkg::res_t     res1
);
  import dpd_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);
  localparam logic [CNT_W:0] MAX_C = (CNT_W + 1)'(MAX_FRAME_LEN);

  typedef enum logic [7:0] {
    ST_HUNT       = 8'b0000_0001,
    ST_ONE_DELIM  = 8'b0000_0010,
    ST_TWO_DELIM  = 8'b0000_0100,
    ST_PAYLOAD    = 8'b0000_1000,
    ST_ONE_TAIL   = 8'b0001_0000,
    ST_POT_HEAD   = 8'b0010_0000,
    ST_UNEXP_HEAD = 8'b0100_0000,
    ST_DISCARD    = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [CNT_W:0]    sum1, sum2;
  logic [CNT_W-1:0]  cnt_add1, cnt_add2;
  logic [CNT_W+10:0] cnt_ext;
  logic [10:0]       cnt_len;
  logic              is_delim, is_head, is_tail;

  assign is_delim = (rx_byte == cfg.delimiter_byte);
  assign is_head  = (rx_byte == cfg.head_byte);
  assign is_tail  = (rx_byte == cfg.tail_byte);

  assign sum1     = {1'b0, cnt_r} + (CNT_W + 1)'(1);
  assign sum2     = {1'b0, cnt_r} + (CNT_W + 1)'(2);
  assign cnt_add1 = (sum1 > MAX_C) ? MAX_C[CNT_W-1:0] : sum1[CNT_W-1:0];
  assign cnt_add2 = (sum2 > MAX_C) ? MAX_C[CNT_W-1:0] : sum2[CNT_W-1:0];

  // The reported length is the low 11 bits of the count.
  assign cnt_ext = {11'd0, cnt_r};
  assign cnt_len = cnt_ext[10:0];

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    res_cnt   = 2'd0;
    res0      = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, frame_length: 11'd0, last: 1'b1};
    res1      = '{kind: KIND_PAYLOAD, payload_byte: rx_byte, frame_length: 11'd0, last: 1'b1};
    unique case (state_r)
      ST_ONE_DELIM: begin
        if (is_delim) begin
          state_nxt = ST_TWO_DELIM;
        end else if (is_head) begin
          state_nxt = ST_PAYLOAD;
          cnt_nxt   = '0;
        end else begin
          state_nxt = ST_HUNT;
        end
      end
      ST_TWO_DELIM: begin
        if (is_head) begin
          state_nxt = ST_PAYLOAD;
          cnt_nxt   = '0;
        end else begin
          state_nxt = ST_HUNT;
        end
      end
      ST_PAYLOAD: begin
        if (is_tail) begin
          held_nxt  = rx_byte;
          state_nxt = ST_ONE_TAIL;
        end else if (is_delim) begin
          held_nxt  = rx_byte;
          state_nxt = ST_POT_HEAD;
        end else begin
          res_cnt           = 2'd1;
          res0.payload_byte = rx_byte;
          cnt_nxt           = cnt_add1;
        end
      end
      ST_ONE_TAIL: begin
        if (is_tail || is_delim) begin
          res_cnt           = 2'd1;
          res0.kind         = KIND_DONE;
          res0.frame_length = cnt_len;
          cnt_nxt           = '0;
          state_nxt         = ST_HUNT;
        end else begin
          res_cnt           = 2'd2;
          res0.payload_byte = held_r;
          res0.last         = 1'b0;
          cnt_nxt           = cnt_add2;
          state_nxt         = ST_PAYLOAD;
        end
      end
      ST_POT_HEAD: begin
        if (is_delim) begin
          state_nxt = ST_UNEXP_HEAD;
        end else if (is_head) begin
          res_cnt           = 2'd1;
          res0.kind         = KIND_DONE;
          res0.frame_length = cnt_len;
          cnt_nxt           = '0;
          state_nxt         = ST_PAYLOAD;
        end else begin
          res_cnt           = 2'd2;
          res0.payload_byte = held_r;
          res0.last         = 1'b0;
          cnt_nxt           = cnt_add2;
          state_nxt         = ST_PAYLOAD;
        end
      end
      ST_UNEXP_HEAD: begin
        res_cnt = 2'd1;
        cnt_nxt = '0;
        if (is_head) begin
          res0.kind         = KIND_DONE;
          res0.frame_length = cnt_len;
          state_nxt         = ST_PAYLOAD;
        end else begin
          res0.kind = KIND_ERROR;
          state_nxt = burst_end ? ST_HUNT : ST_DISCARD;
        end
      end
      ST_DISCARD: begin
        if (burst_end) begin
          state_nxt = ST_HUNT;
        end
      end
      default: begin
        // Header hunt, and any corrupted state code.
        state_nxt = is_delim ? ST_ONE_DELIM : ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      held_r  <= 8'd0;
      cnt_r   <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/dpd_result_fifo.sv =====
// Four-entry queue: takes up to two results per cycle, gives one unless stalled.
module dpd_result_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_cnt,
  input  dpd_pkg::res_t push0,
  input  dpd_pkg::res_t push1,
  output logic          room,
  output logic          out_valid,
  input  logic          out_stall,
  output dpd_pkg::res_t out_res
);
  import dpd_pkg::*;

  res_t       mem [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] fill_r, fill_nxt;
  logic       pop;
  logic [1:0] wr_ptr_p1;

  assign out_valid = (fill_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign room      = (fill_r <= 3'd2);
  assign out_res   = mem[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + 2'd1;
  assign fill_nxt  = fill_r + {1'b0, push_cnt} - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      fill_r   <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_cnt;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== hw/rtl/delimited_packet_deframer.sv =====
// Top level of the delimited packet deframer: input stage, parser and result queue.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_rx_byte, in_burst_end
//   out      output     out_valid / out_stall out_kind, out_payload_byte,
//                                             out_frame_length, out_last
//   cfg      input      cfg_wr_en             cfg_index, cfg_wdata
//
// A byte is registered in the input stage on its transfer and parsed once the result
// queue has room; its results then enter the queue, whose head drives the output.
// One byte can be taken every cycle while the result queue holds two or fewer entries;
// a byte that makes two payload results costs two output transfers. Reset is synchronous
// and clears the parser to header hunt and empties the queue. A stall on the output backs
// up through the queue to the input stage.
module delimited_packet_deframer #(
  parameter int MAX_FRAME_LEN = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_wdata,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_rx_byte,
  input  logic          in_burst_end,
  output logic          out_valid,
  input  logic          out_stall,
  output dpd_pkg::kind_t out_kind,
  output logic [7:0]    out_payload_byte,
  output logic [10:0]   out_frame_length,
  output logic          out_last
);
  import dpd_pkg::*;

  cfg_t       cfg_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_bend_r;
  logic       accept, fire, room;
  logic [1:0] res_cnt, push_cnt;
  res_t       res0, res1, out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter_byte <= DELIMITER_RST;
      cfg_r.head_byte      <= HEAD_RST;
      cfg_r.tail_byte      <= TAIL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DELIMITER: cfg_r.delimiter_byte <= cfg_wdata;
        REG_HEAD:      cfg_r.head_byte      <= cfg_wdata;
        REG_TAIL:      cfg_r.tail_byte      <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  assign fire     = s1_valid_r && room;
  assign in_stall = s1_valid_r && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_rx_byte;
      s1_bend_r <= in_burst_end;
    end
  end

  dpd_parser #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .fire     (fire),
    .rx_byte  (s1_byte_r),
    .burst_end(s1_bend_r),
    .res_cnt  (res_cnt),
    .res0     (res0),
    .res1     (res1)
  );

  assign push_cnt = fire ? res_cnt : 2'd0;

  dpd_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .push0    (res0),
    .push1    (res1),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_payload_byte = out_res.payload_byte;
  assign out_frame_length = out_res.frame_length;
  assign out_last         = out_res.last;

`ifndef SYNTHESIS
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input stage");

  a_two_results_show: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_cnt == 2'd2) |=> out_valid)
    else $error("two results pushed but output not valid");

  a_error_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_ERROR) |-> (out_last && out_frame_length == 11'd0))
    else $error("framing error result malformed");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the delimited packet deframer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dpd_pkg::*;

  localparam int FRAME_CAP   = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 20;

  // Directed bytes as {burst_end, rx_byte}, written for the reset register values.
  localparam logic [8:0] DIRECTED [29] = '{
    9'h155, 9'h0FF, 9'h000, 9'h000, 9'h0EF, 9'h034, 9'h0FF, 9'h056, 9'h0EF, 9'h0EF,
    9'h0FF, 9'h0FF, 9'h000, 9'h0FF, 9'h000, 9'h0FF, 9'h0FF, 9'h033, 9'h144, 9'h0FF,
    9'h000, 9'h0FF, 9'h0FF, 9'h101, 9'h0FF, 9'h000, 9'h07F, 9'h0EF, 9'h1FF
  };

  typedef enum logic [2:0] {
    HUNT, SAW_DELIM, SAW_TWO_DELIMS, IN_PAYLOAD,
    HELD_TAIL, HELD_DELIM, HELD_TWO_DELIMS, SKIP_BURST
  } parse_t;

  typedef struct {
    logic [7:0] b;
    logic       bend;
    int         gap;
    bit         slow_out;
  } rx_item_t;

  typedef struct {
    res_t r;
    bit   slow;
  } pending_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_DELIMITER;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        in_burst_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  kind_t       out_kind;
  logic [7:0]  out_payload_byte;
  logic [10:0] out_frame_length;
  logic        out_last;

  // Shadow copies of the registers and the parser state.
  logic [7:0] delim_cfg = DELIMITER_RST;
  logic [7:0] head_cfg  = HEAD_RST;
  logic [7:0] tail_cfg  = TAIL_RST;
  parse_t     parse_st  = HUNT;
  logic [7:0] held_byte = 8'd0;
  int         frame_count = 0;

  rx_item_t     rx_byte_q[$];
  pending_res_t deframed_q[$];
  res_t         step_results[$];

  bit in_slow  = 1'b0;
  bit out_slow = 1'b0;
  bit cur_slow_out = 1'b0;
  int gap_count = 0;
  int stall_left = 0;
  int pushed = 0;
  int bytes_sent = 0;
  int payload_seen = 0;
  int frames_seen = 0;
  int errors_seen = 0;
  int mismatches = 0;
  int cycles = 0;

  delimited_packet_deframer #(.MAX_FRAME_LEN(FRAME_CAP)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_rx_byte(in_rx_byte), .in_burst_end(in_burst_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_payload_byte(out_payload_byte),
    .out_frame_length(out_frame_length), .out_last(out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void emit(kind_t k, logic [7:0] pb, int len);
    res_t r;
    r.kind = k;
    r.payload_byte = pb;
    r.frame_length = 11'(len);
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void bump_count(int n);
    frame_count = (frame_count + n > FRAME_CAP) ? FRAME_CAP : frame_count + n;
  endfunction

  // A held byte that did not start a trailer or header goes out with the current one.
  function automatic void release_pair(logic [7:0] b);
    emit(KIND_PAYLOAD, held_byte, 0);
    emit(KIND_PAYLOAD, b, 0);
    bump_count(2);
    parse_st = IN_PAYLOAD;
  endfunction

  function automatic void finish_frame(parse_t next_st);
    emit(KIND_DONE, 8'd0, frame_count);
    frame_count = 0;
    parse_st = next_st;
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic bend, bit slow);
    pending_res_t p;
    step_results.delete();
    case (parse_st)
      SAW_DELIM: begin
        if (b == delim_cfg) parse_st = SAW_TWO_DELIMS;
        else if (b == head_cfg) begin
          parse_st = IN_PAYLOAD;
          frame_count = 0;
        end else parse_st = HUNT;
      end
      SAW_TWO_DELIMS: begin
        if (b == head_cfg) begin
          parse_st = IN_PAYLOAD;
          frame_count = 0;
        end else parse_st = HUNT;
      end
      IN_PAYLOAD: begin
        if (b == tail_cfg) begin
          held_byte = b;
          parse_st = HELD_TAIL;
        end else if (b == delim_cfg) begin
          held_byte = b;
          parse_st = HELD_DELIM;
        end else begin
          emit(KIND_PAYLOAD, b, 0);
          bump_count(1);
        end
      end
      HELD_TAIL: begin
        if (b == tail_cfg || b == delim_cfg) finish_frame(HUNT);
        else release_pair(b);
      end
      HELD_DELIM: begin
        if (b == delim_cfg) parse_st = HELD_TWO_DELIMS;
        else if (b == head_cfg) finish_frame(IN_PAYLOAD);
        else release_pair(b);
      end
      HELD_TWO_DELIMS: begin
        if (b == head_cfg) finish_frame(IN_PAYLOAD);
        else begin
          emit(KIND_ERROR, 8'd0, 0);
          frame_count = 0;
          parse_st = bend ? HUNT : SKIP_BURST;
        end
      end
      SKIP_BURST: begin
        if (bend) parse_st = HUNT;
      end
      default: parse_st = (b == delim_cfg) ? SAW_DELIM : HUNT;
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) begin
      p.r = step_results[i];
      p.slow = slow;
      deframed_q.push_back(p);
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Driver: presents queued bytes, idling between them as each item asks.
  always @(posedge clk) begin : driver
    rx_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_rx_byte, in_burst_end, cur_slow_out);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (rx_byte_q.size() == 0) in_valid <= 1'b0;
        else if (gap_count < rx_byte_q[0].gap) begin
          gap_count++;
          in_valid <= 1'b0;
        end else begin
          nxt = rx_byte_q.pop_front();
          in_valid <= 1'b1;
          in_rx_byte <= nxt.b;
          in_burst_end <= nxt.bend;
          cur_slow_out = nxt.slow_out;
          gap_count = 0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and stalls the output at random.
  always @(posedge clk) begin : monitor
    pending_res_t want;
    bit slow;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        slow = 1'b1;
        if (deframed_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, kind %0d byte %0d length %0d",
                   $time, out_kind, out_payload_byte, out_frame_length);
        end else begin
          want = deframed_q.pop_front();
          slow = want.slow;
          check_field("kind", int'(want.r.kind), int'(out_kind));
          check_field("payload_byte", want.r.payload_byte, out_payload_byte);
          check_field("frame_length", want.r.frame_length, out_frame_length);
          check_field("last", want.r.last, out_last);
        end
        case (out_kind)
          KIND_PAYLOAD: payload_seen++;
          KIND_DONE:    frames_seen++;
          default:      errors_seen++;
        endcase
        if (deframed_q.size() > 0) slow = deframed_q[0].slow;
        stall_left = slow ? $urandom_range(0, 15) : 0;
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, deframed_q.size());
      $display("delimited_packet_deframer test failed");
      $finish;
    end
  end

  function automatic bit burst_flag();
    return $urandom_range(0, 7) == 0;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255));
    while (v == delim_cfg || v == head_cfg || v == tail_cfg);
    return v;
  endfunction

  task automatic push_byte(logic [7:0] b, logic bend);
    rx_item_t it;
    it.b = b;
    it.bend = bend;
    it.gap = in_slow ? $urandom_range(0, 15) : 0;
    it.slow_out = out_slow;
    rx_byte_q.push_back(it);
    pushed++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_DELIMITER: delim_cfg = val;
      REG_HEAD:      head_cfg = val;
      default:       tail_cfg = val;
    endcase
  endtask

  task automatic write_regs(logic [7:0] d, logic [7:0] h, logic [7:0] t);
    write_reg(REG_DELIMITER, d);
    write_reg(REG_HEAD, h);
    write_reg(REG_TAIL, t);
  endtask

  // Waits until every byte has gone in and every result has come out, then lets
  // the parser settle on bytes that make no result.
  task automatic drain();
    do @(posedge clk);
    while (rx_byte_q.size() != 0 || in_valid || deframed_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One frame with random content; some break off in a framing error, some lose
  // their trailer so that the next header lands inside the payload.
  task automatic push_frame();
    int len;
    int pick;
    int k;
    int j;
    logic bend;
    if ($urandom_range(0, 1)) push_byte(delim_cfg, burst_flag());
    push_byte(delim_cfg, burst_flag());
    push_byte(head_cfg, burst_flag());
    len = $urandom_range(0, 12);
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) push_byte(plain_byte(), burst_flag());
      else if (pick < 13) begin
        push_byte(tail_cfg, burst_flag());
        push_byte(plain_byte(), burst_flag());
      end else if (pick < 15) begin
        push_byte(delim_cfg, burst_flag());
        push_byte(plain_byte(), burst_flag());
      end else if (pick == 15) begin
        push_byte(delim_cfg, burst_flag());
        push_byte(head_cfg, burst_flag());
      end else if (pick == 16) begin
        push_byte(delim_cfg, burst_flag());
        push_byte(delim_cfg, burst_flag());
        push_byte(head_cfg, burst_flag());
      end else if (pick < 19) push_byte(8'($urandom_range(0, 255)), burst_flag());
      else begin
        bend = $urandom_range(0, 3) == 0;
        push_byte(delim_cfg, burst_flag());
        push_byte(delim_cfg, burst_flag());
        push_byte(plain_byte(), bend);
        if (!bend) begin
          for (j = $urandom_range(0, 3); j > 0; j--)
            push_byte(8'($urandom_range(0, 255)), 1'b0);
          push_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        return;
      end
    end
    if ($urandom_range(0, 7) != 0) begin
      push_byte(tail_cfg, burst_flag());
      push_byte($urandom_range(0, 1) ? tail_cfg : delim_cfg, burst_flag());
    end
  endtask

  task automatic run_random(int target);
    int start;
    int j;
    start = pushed;
    while (pushed - start < target) begin
      if ($urandom_range(0, 5) == 0) begin
        in_slow = $urandom_range(0, 1);
        out_slow = $urandom_range(0, 1);
      end
      if ($urandom_range(0, 9) == 0) begin
        for (j = $urandom_range(1, 3); j > 0; j--)
          push_byte(8'($urandom_range(0, 255)), burst_flag());
      end else push_frame();
    end
  endtask

  // A frame long enough to run the length counter into its cap.
  task automatic push_long_frame();
    int len;
    in_slow = 1'b0;
    out_slow = 1'b0;
    len = 0;
    push_byte(delim_cfg, 1'b0);
    push_byte(head_cfg, 1'b0);
    while (len < FRAME_CAP + 80) begin
      if ($urandom_range(0, 15) == 0) begin
        push_byte(tail_cfg, 1'b0);
        len++;
      end
      push_byte(plain_byte(), burst_flag());
      len++;
    end
    push_byte(tail_cfg, 1'b0);
    push_byte(tail_cfg, 1'b1);
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    in_slow = 1'b1;
    out_slow = 1'b1;
    foreach (DIRECTED[i]) push_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    run_random(75);
    drain();

    write_regs(8'h00, 8'hFF, 8'h01);
    run_random(75);
    drain();

    // All three codes equal: tail wins in the payload, delimiter after a delimiter.
    write_regs(8'h7E, 8'h7E, 8'h7E);
    run_random(75);
    drain();

    write_regs(8'h10, 8'h10, 8'h20);
    run_random(75);
    drain();

    write_regs(8'hA5, 8'h5A, 8'hA5);
    run_random(75);
    drain();

    write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
    run_random(75);
    push_long_frame();
    drain();

    $display("Sent %0d bytes under six register settings, one frame past the length cap.",
             bytes_sent);
    $display("Checked %0d payload bytes, %0d finished frames and %0d framing errors.",
             payload_seen, frames_seen, errors_seen);
    if (mismatches == 0) begin
      $display("delimited_packet_deframer test passed");
    end else begin
      $display("delimited_packet_deframer test failed");
    end
    $finish;
  end

endmodule
